/* rtl/core/nmd_pkg.sv */
// ----------------------------------------------------------------------------
// nmd_pkg
// Shared constants and types of the displacement-to-normal-map block.
// ----------------------------------------------------------------------------
package nmd_pkg;

    // Line store depth and the address width that follows from it.
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    // Field widths fixed by the interface.
    localparam int COL_W  = 11;
    localparam int ROW_W  = 12;
    localparam int COMP_W = 16;
    localparam int PIX_W  = 3 * COMP_W;
    localparam int CFG_W  = 12;

    // Configuration register indexes.
    localparam logic CFG_LAST_COLUMN = 1'b0;
    localparam logic CFG_LAST_ROW    = 1'b1;

    // Byte for a zero-length normal.
    localparam logic [7:0] ZERO_NORMAL = 8'd127;

    typedef logic [PIX_W-1:0] t_pix;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_SEL,
        S_MUL,
        S_CROSS,
        S_MAG,
        S_SHIFT,
        S_RED,
        S_SQ,
        S_SUM,
        S_SA,
        S_SB,
        S_SC,
        S_OUT
    } t_state;

endpackage

/* rtl/core/normal_map_from_displacement.sv */
// Each item first reads the line stores (S_RD1, S_RD2), then, for each normal
// it produces, runs the cross product, reduction, and an 8-step search per
// byte in three parallel lanes, and returns to S_SEL, which retires the item.
// An item yields no normal, one, or up to three on the last row; a new item
// is taken only in S_IDLE, after the previous one has retired.
// Reset clears counters, configuration (both registers to 1) and handshakes;
// the line stores are not cleared.
// ----------------------------------------------------------------------------
// normal_map_from_displacement
// Streams a displacement patch in raster order and emits normalized normals
// as three bytes per pixel, one row behind the input.
// ----------------------------------------------------------------------------
module normal_map_from_displacement
    import nmd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration write port
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    // Input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [COMP_W-1:0] i_disp_x,
    input  logic signed [COMP_W-1:0] i_disp_y,
    input  logic signed [COMP_W-1:0] i_disp_z,
    // Output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [7:0]               o_normal_r,
    output logic [7:0]               o_normal_g,
    output logic [7:0]               o_normal_b,
    output logic [COL_W-1:0]         o_out_column,
    output logic [ROW_W-1:0]         o_out_row,
    output logic                     o_run_last,
    output logic                     o_patch_done
);

    t_state r_state, n_state;

    // Configuration and position counters.
    logic [COL_W-1:0] r_last_column;
    logic [ROW_W-1:0] r_last_row;
    logic [COL_W-1:0] r_col_cnt;
    logic [ROW_W-1:0] r_row_cnt;

    // Per-item context.
    logic [COL_W-1:0] r_c, r_lc;
    logic [ROW_W-1:0] r_r;
    logic             r_bottom;
    logic [2:0]       r_jobs;
    t_pix             r_p, r_mid, r_up, r_right;
    t_pix             r_prev_mid, r_bleft, r_bprev;

    // Line stores.
    t_pix              upper_mem  [MAX_WIDTH];
    t_pix              middle_mem [MAX_WIDTH];
    t_pix              r_up_rd, r_mid_rd;
    logic [ADDR_W-1:0] rd_addr;

    // Normal datapath.
    logic signed [16:0] r_du [3];
    logic signed [16:0] r_dv [3];
    logic signed [33:0] r_pr [6];
    logic signed [35:0] r_n  [3];
    logic [34:0]        r_mag [3];
    logic               r_neg [3];
    logic [34:0]        r_mx;
    logic [3:0]         r_sh;
    logic [19:0]        r_red [3];
    logic [39:0]        r_sq  [3];
    logic [27:0]        r_babs [3];
    logic               r_bneg [3];
    logic [41:0]        r_s;
    logic [55:0]        r_bb  [3];
    logic [7:0]         r_lo  [3];
    logic [7:0]         r_bit;
    logic [15:0]        r_asq [3];
    logic               r_apos [3];
    logic [36:0]        r_plo [3];
    logic [36:0]        r_phi [3];

    // Job tags.
    logic [COL_W-1:0] r_o_col;
    logic [ROW_W-1:0] r_o_row;
    logic             r_o_last, r_o_done;

    // Output register.
    logic             r_out_valid;
    logic [7:0]       r_out_byte [3];
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;
    logic             r_out_last, r_out_done;

    logic             in_accept, out_free;
    logic [COL_W-1:0] lc_eff, c_eff;
    logic [ROW_W-1:0] r_eff;

    // Effective position of the incoming pixel.
    always_comb begin
        lc_eff = ({1'b0, r_last_column} > (COL_W+1)'(MAX_WIDTH - 1)) ?
                 COL_W'(MAX_WIDTH - 1) : r_last_column;
        c_eff  = (r_col_cnt > lc_eff) ? '0 : r_col_cnt;
        r_eff  = (r_row_cnt > r_last_row) ? '0 : r_row_cnt;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_SEL;
            S_SEL:   n_state = (r_jobs == 3'b000) ? S_IDLE : S_MUL;
            S_MUL:   n_state = S_CROSS;
            S_CROSS: n_state = S_MAG;
            S_MAG:   n_state = S_SHIFT;
            S_SHIFT: n_state = S_RED;
            S_RED:   n_state = S_SQ;
            S_SQ:    n_state = S_SUM;
            S_SUM:   n_state = S_SA;
            S_SA:    n_state = S_SB;
            S_SB:    n_state = S_SC;
            S_SC:    n_state = r_bit[0] ? S_OUT : S_SA;
            S_OUT:   if (out_free) n_state = S_SEL;
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration registers and position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_column <= COL_W'(1);
            r_last_row    <= ROW_W'(1);
            r_col_cnt     <= '0;
            r_row_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LAST_COLUMN) begin
                    r_last_column <= i_cfg_data[COL_W-1:0];
                end else begin
                    r_last_row <= i_cfg_data[ROW_W-1:0];
                end
            end
            if (in_accept) begin
                if (c_eff >= lc_eff) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= (r_eff >= r_last_row) ? '0 : r_eff + ROW_W'(1);
                end else begin
                    r_col_cnt <= c_eff + COL_W'(1);
                end
            end
        end
    end

    // Line stores: read at the item column, then at the column to its right.
    assign rd_addr = (r_state == S_RD1) ? ADDR_W'(r_c + COL_W'(1)) : ADDR_W'(c_eff);

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD2) begin
            upper_mem[ADDR_W'(r_c)]  <= r_mid;
            middle_mem[ADDR_W'(r_c)] <= r_p;
        end
        r_up_rd  <= upper_mem[rd_addr];
        r_mid_rd <= middle_mem[rd_addr];
    end

    // Operand selection for the next pending normal.
    t_pix               w_l, w_r, w_u, w_d;
    logic [2:0]         jobs_left;
    logic [COL_W-1:0]   sel_col;
    logic [ROW_W-1:0]   sel_row;
    logic               sel_done;

    always_comb begin
        w_l = r_mid; w_r = r_mid; w_u = r_mid; w_d = r_p;
        sel_col = r_c; sel_row = r_r - ROW_W'(1); sel_done = 1'b0;
        jobs_left = r_jobs;
        if (r_jobs[0]) begin
            // Pixel one row up.
            w_l = (r_c != '0) ? r_prev_mid : r_mid;
            w_r = (r_c < r_lc) ? r_right : r_mid;
            w_u = (r_r >= ROW_W'(2)) ? r_up : r_mid;
            w_d = r_p;
            jobs_left[0] = 1'b0;
        end else if (r_jobs[1]) begin
            // Bottom-row pixel one column back.
            w_l = (r_c >= COL_W'(2)) ? r_bleft : r_bprev;
            w_r = r_p;
            w_u = (r_r != '0) ? r_prev_mid : r_bprev;
            w_d = r_bprev;
            sel_col = r_c - COL_W'(1);
            sel_row = r_r;
            jobs_left[1] = 1'b0;
        end else begin
            // Final pixel of the patch.
            w_l = (r_c != '0) ? r_bprev : r_p;
            w_r = r_p;
            w_u = (r_r != '0) ? r_mid : r_p;
            w_d = r_p;
            sel_row = r_r;
            sel_done = 1'b1;
            jobs_left[2] = 1'b0;
        end
    end

    // Shift amount that brings the largest magnitude below 2^20.
    logic [3:0] sh_calc;
    always_comb begin
        sh_calc = '0;
        for (int b = 20; b < 35; b++) begin
            if (r_mx[b]) sh_calc = 4'(b - 19);
        end
    end

    // Search lane helpers.
    logic signed [9:0] lane_a   [3];
    logic [7:0]        lane_abs [3];
    logic [57:0]       lane_aa  [3];
    logic              lane_ok  [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lane_a[i]   = $signed({1'b0, r_lo[i] | r_bit, 1'b0}) - 10'sd255;
            lane_abs[i] = lane_a[i][9] ? 8'(-lane_a[i]) : 8'(lane_a[i]);
            lane_aa[i]  = {r_phi[i], 21'b0} + 58'(r_plo[i]);
            if (r_apos[i]) begin
                lane_ok[i] = !r_bneg[i] && (lane_aa[i] <= 58'(r_bb[i]));
            end else begin
                lane_ok[i] = !r_bneg[i] || (lane_aa[i] >= 58'(r_bb[i]));
            end
        end
    end

    // Item context, operand fetch and normal datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bleft <= '0;
            r_bprev <= '0;
            r_jobs  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_c      <= c_eff;
                        r_r      <= r_eff;
                        r_lc     <= lc_eff;
                        r_bottom <= (r_eff == r_last_row);
                        r_p      <= {i_disp_z, i_disp_y, i_disp_x};
                        r_jobs   <= {(r_eff == r_last_row) && (c_eff == lc_eff),
                                     (r_eff == r_last_row) && (c_eff != '0),
                                     (r_eff != '0)};
                    end
                end
                S_RD1: begin
                    r_mid <= r_mid_rd;
                    r_up  <= r_up_rd;
                end
                S_RD2: begin
                    r_right <= r_mid_rd;
                end
                S_SEL: begin
                    if (r_jobs == 3'b000) begin
                        // Retire the item: shift the neighbor history.
                        r_prev_mid <= r_mid;
                        if (r_bottom) begin
                            r_bleft <= r_bprev;
                            r_bprev <= r_p;
                        end
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            r_du[i] <= $signed({w_r[16*i+15], w_r[16*i +: 16]})
                                     - $signed({w_l[16*i+15], w_l[16*i +: 16]});
                            r_dv[i] <= $signed({w_d[16*i+15], w_d[16*i +: 16]})
                                     - $signed({w_u[16*i+15], w_u[16*i +: 16]});
                        end
                        r_jobs   <= jobs_left;
                        r_o_col  <= sel_col;
                        r_o_row  <= sel_row;
                        r_o_done <= sel_done;
                        r_o_last <= (jobs_left == 3'b000);
                    end
                end
                S_MUL: begin
                    r_pr[0] <= r_du[1] * r_dv[2];
                    r_pr[1] <= r_du[2] * r_dv[1];
                    r_pr[2] <= r_du[2] * r_dv[0];
                    r_pr[3] <= r_du[0] * r_dv[2];
                    r_pr[4] <= r_du[0] * r_dv[1];
                    r_pr[5] <= r_du[1] * r_dv[0];
                end
                S_CROSS: begin
                    for (int i = 0; i < 3; i++) begin
                        r_n[i] <= 36'(r_pr[2*i]) - 36'(r_pr[2*i+1]);
                    end
                end
                S_MAG: begin
                    logic [34:0] m0, m1, m2;
                    m0 = r_n[0][35] ? 35'(-r_n[0]) : 35'(r_n[0]);
                    m1 = r_n[1][35] ? 35'(-r_n[1]) : 35'(r_n[1]);
                    m2 = r_n[2][35] ? 35'(-r_n[2]) : 35'(r_n[2]);
                    r_mag[0] <= m0;
                    r_mag[1] <= m1;
                    r_mag[2] <= m2;
                    for (int i = 0; i < 3; i++) r_neg[i] <= r_n[i][35];
                    r_mx <= (m0 >= m1) ? ((m0 >= m2) ? m0 : m2)
                                       : ((m1 >= m2) ? m1 : m2);
                end
                S_SHIFT: begin
                    r_sh <= sh_calc;
                end
                S_RED: begin
                    for (int i = 0; i < 3; i++) r_red[i] <= 20'(r_mag[i] >> r_sh);
                end
                S_SQ: begin
                    for (int i = 0; i < 3; i++) begin
                        r_sq[i]   <= 40'(r_red[i]) * 40'(r_red[i]);
                        r_babs[i] <= 28'({r_red[i], 8'b0}) - 28'(r_red[i]);
                        r_bneg[i] <= r_neg[i] && (r_red[i] != '0);
                    end
                end
                S_SUM: begin
                    r_s <= 42'(r_sq[0]) + 42'(r_sq[1]) + 42'(r_sq[2]);
                    for (int i = 0; i < 3; i++) begin
                        r_bb[i] <= 56'(r_babs[i]) * 56'(r_babs[i]);
                        r_lo[i] <= '0;
                    end
                    r_bit <= 8'h80;
                end
                S_SA: begin
                    for (int i = 0; i < 3; i++) begin
                        r_asq[i]  <= 16'(lane_abs[i]) * 16'(lane_abs[i]);
                        r_apos[i] <= !lane_a[i][9];
                    end
                end
                S_SB: begin
                    for (int i = 0; i < 3; i++) begin
                        r_plo[i] <= 37'(r_asq[i]) * 37'(r_s[20:0]);
                        r_phi[i] <= 37'(r_asq[i]) * 37'(r_s[41:21]);
                    end
                end
                S_SC: begin
                    for (int i = 0; i < 3; i++) begin
                        if (lane_ok[i]) r_lo[i] <= r_lo[i] | r_bit;
                    end
                    r_bit <= r_bit >> 1;
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: loads when the slot is empty or being emptied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            for (int i = 0; i < 3; i++) begin
                r_out_byte[i] <= (r_s == '0) ? ZERO_NORMAL : r_lo[i];
            end
            r_out_col  <= r_o_col;
            r_out_row  <= r_o_row;
            r_out_last <= r_o_last;
            r_out_done <= r_o_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_normal_r   = r_out_byte[0];
    assign o_normal_g   = r_out_byte[1];
    assign o_normal_b   = r_out_byte[2];
    assign o_out_column = r_out_col;
    assign o_out_row    = r_out_row;
    assign o_run_last   = r_out_last;
    assign o_patch_done = r_out_done;

    // An accepted transaction always starts the line store read sequence.
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == S_RD1)
        else $error("accepted transaction did not start the store read");

    // A normal waits in S_OUT while the output register is still occupied.
    a_out_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_out_ready) |=> r_state == S_OUT)
        else $error("normal overwrote a pending output transaction");

    // The search pointer walks one bit at a time.
    a_search_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SA || r_state == S_SB || r_state == S_SC) |-> $onehot(r_bit))
        else $error("search bit pointer corrupted");

    // The final patch pixel is always the last normal of its transaction.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_patch_done) |-> o_run_last)
        else $error("patch end flagged on a normal that is not the last");

endmodule
